FILE: hw/rtl/swc_pkg.sv
// ----------------------------------------------------------------------------
// swc_pkg
// shared types, constants and codes of the sliding window clahe block
// ----------------------------------------------------------------------------
package swc_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_RADIUS_DEF = 32;
    localparam int BINS           = 256;
    localparam int BIN_W          = 8;
    localparam int HEIGHT_CAP     = 1024;
    localparam int ROW_W          = 10;
    localparam int CFG_W_W        = 11;
    localparam int CFG_H_W        = 11;
    localparam int CFG_R_W        = 6;
    localparam int CLIP_W         = 12;
    localparam int PADDR_W        = 4;
    localparam int PDATA_W        = 32;

    localparam logic [CFG_W_W-1:0] WIDTH_RST  = 11'd896;
    localparam logic [CFG_H_W-1:0] HEIGHT_RST = 11'd896;
    localparam logic [CFG_R_W-1:0] RADIUS_RST = 6'd32;
    localparam logic [CLIP_W-1:0]  CLIP_RST   = 12'd512;

    // register index, taken from paddr[3:2]
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_RADIUS = 2'd2;
    localparam logic [1:0] REG_CLIP   = 2'd3;

    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef struct packed {
        logic             opcode;
        logic [BIN_W-1:0] pixel_in;
    } t_in_item;

    typedef struct packed {
        logic [BIN_W-1:0] pixel_out;
        logic             last;
    } t_out_item;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_SETUP,
        BK_THR,
        BK_THR2,
        BK_THR3,
        BK_WRD,
        BK_WBIN,
        BK_WINC,
        BK_CLRD,
        BK_CLWR,
        BK_SUMRD,
        BK_SUMAC,
        BK_MUL,
        BK_DIV,
        BK_DONE
    } t_back_state;

endpackage

FILE: hw/rtl/swc_ram.sv
// ----------------------------------------------------------------------------
// swc_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module swc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hw/rtl/swc_front.sv
// ----------------------------------------------------------------------------
// swc_front
// accepts items, stores pixels in the row ring and issues output jobs
// ----------------------------------------------------------------------------
module swc_front #(
    parameter int MAX_WIDTH  = swc_pkg::MAX_WIDTH_DEF,
    parameter int MAX_RADIUS = swc_pkg::MAX_RADIUS_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_in_valid,
    input  swc_pkg::t_in_item                             i_in_data,
    output logic                                          o_in_stall,
    input  logic                                          i_cfg_wr,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]                i_eff_w,
    input  logic [swc_pkg::CFG_H_W-1:0]                   i_eff_h,
    input  logic [$clog2(MAX_RADIUS+1)-1:0]               i_eff_r,
    input  logic                                          i_back_busy,
    input  logic                                          i_job_take,
    output logic                                          o_job_valid,
    output logic [swc_pkg::ROW_W-1:0]                     o_job_row,
    output logic [$clog2(MAX_WIDTH)-1:0]                  o_job_col,
    output logic [$clog2(2*MAX_RADIUS+2)-1:0]             o_job_slot,
    output logic                                          o_job_last,
    output logic                                          o_ram_we,
    output logic [$clog2((2*MAX_RADIUS+2)*MAX_WIDTH)-1:0] o_ram_waddr,
    output logic [swc_pkg::BIN_W-1:0]                     o_ram_wdata
);
    import swc_pkg::*;

    localparam int SLOTS = 2 * MAX_RADIUS + 2;
    localparam int SLOTW = $clog2(SLOTS);
    localparam int COLW  = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int RW    = $clog2(MAX_RADIUS + 1);
    localparam int ADDRW = $clog2(SLOTS * MAX_WIDTH);
    localparam int DW    = $clog2(HEIGHT_CAP * MAX_WIDTH + 1);

    logic [COLW-1:0]  r_in_col, r_out_col;
    logic [ROW_W-1:0] r_in_row, r_out_row;
    logic [SLOTW-1:0] r_in_slot, r_out_slot;
    logic             r_in_done;
    logic [DW-1:0]    r_d;
    logic             r_q_valid;
    logic [ROW_W-1:0] r_q_row;
    logic [COLW-1:0]  r_q_col;
    logic [SLOTW-1:0] r_q_slot;
    logic             r_q_last;

    logic             c_accept, c_push, c_emit, c_last;
    logic [WW-1:0]    c_wm1;
    logic [COLW-1:0]  c_wm1_col;
    logic [ROW_W-1:0] c_hm1;
    logic [DW-1:0]    c_lag, c_d_inc;

    assign o_in_stall = r_q_valid || i_back_busy;
    assign c_accept   = i_in_valid && !o_in_stall;

    assign c_wm1     = i_eff_w - WW'(1);
    assign c_wm1_col = COLW'(c_wm1);
    assign c_hm1     = ROW_W'(i_eff_h - CFG_H_W'(1));

    // results trail the input by r rows plus r pixels, less on narrow images
    always_comb begin
        c_lag = DW'(i_eff_r) * DW'(i_eff_w);
        if (WW'(i_eff_r) < c_wm1) begin
            c_lag = c_lag + DW'(i_eff_r);
        end else begin
            c_lag = c_lag + DW'(c_wm1);
        end
    end

    assign c_d_inc = r_d + DW'(1);
    assign c_push  = c_accept && (i_in_data.opcode == OP_PUSH) && !r_in_done;
    assign c_emit  = c_accept && ((i_in_data.opcode == OP_PUSH) ?
                     (!r_in_done && (c_d_inc > c_lag)) : r_in_done);
    assign c_last  = (r_out_row >= c_hm1) && (r_out_col >= c_wm1_col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_in_slot  <= '0;
            r_in_done  <= 1'b0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_out_slot <= '0;
            r_d        <= '0;
            r_q_valid  <= 1'b0;
        end else begin
            if (i_job_take) begin
                r_q_valid <= 1'b0;
            end
            if (i_cfg_wr) begin
                r_in_col   <= '0;
                r_in_row   <= '0;
                r_in_slot  <= '0;
                r_in_done  <= 1'b0;
                r_out_col  <= '0;
                r_out_row  <= '0;
                r_out_slot <= '0;
                r_d        <= '0;
            end else if (c_emit && c_last) begin
                r_in_col   <= '0;
                r_in_row   <= '0;
                r_in_slot  <= '0;
                r_in_done  <= 1'b0;
                r_out_col  <= '0;
                r_out_row  <= '0;
                r_out_slot <= '0;
                r_d        <= '0;
            end else begin
                if (c_push) begin
                    if (r_in_col == c_wm1_col) begin
                        r_in_col  <= '0;
                        r_in_slot <= (r_in_slot == SLOTW'(SLOTS - 1)) ? '0 :
                                     r_in_slot + SLOTW'(1);
                        if (r_in_row == c_hm1) begin
                            r_in_done <= 1'b1;
                        end else begin
                            r_in_row <= r_in_row + ROW_W'(1);
                        end
                    end else begin
                        r_in_col <= r_in_col + COLW'(1);
                    end
                end
                if (c_emit) begin
                    if (r_out_col == c_wm1_col) begin
                        r_out_col  <= '0;
                        r_out_row  <= r_out_row + ROW_W'(1);
                        r_out_slot <= (r_out_slot == SLOTW'(SLOTS - 1)) ? '0 :
                                      r_out_slot + SLOTW'(1);
                    end else begin
                        r_out_col <= r_out_col + COLW'(1);
                    end
                end
                if (c_push && !c_emit) begin
                    r_d <= c_d_inc;
                end else if (!c_push && c_emit) begin
                    r_d <= r_d - DW'(1);
                end
            end
            if (c_emit) begin
                r_q_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_emit) begin
            r_q_row  <= r_out_row;
            r_q_col  <= r_out_col;
            r_q_slot <= r_out_slot;
            r_q_last <= c_last;
        end
    end

    assign o_job_valid = r_q_valid;
    assign o_job_row   = r_q_row;
    assign o_job_col   = r_q_col;
    assign o_job_slot  = r_q_slot;
    assign o_job_last  = r_q_last;

    assign o_ram_we    = c_push;
    assign o_ram_waddr = ADDRW'(r_in_slot) * ADDRW'(MAX_WIDTH) + ADDRW'(r_in_col);
    assign o_ram_wdata = i_in_data.pixel_in;
endmodule

FILE: hw/rtl/swc_back.sv
// ----------------------------------------------------------------------------
// swc_back
// builds, clips and sums the window histogram of one output pixel and divides it to the result
// ----------------------------------------------------------------------------
module swc_back #(
    parameter int MAX_WIDTH  = swc_pkg::MAX_WIDTH_DEF,
    parameter int MAX_RADIUS = swc_pkg::MAX_RADIUS_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]                i_eff_w,
    input  logic [swc_pkg::CFG_H_W-1:0]                   i_eff_h,
    input  logic [$clog2(MAX_RADIUS+1)-1:0]               i_eff_r,
    input  logic [swc_pkg::CLIP_W-1:0]                    i_clip,
    input  logic                                          i_job_valid,
    input  logic [swc_pkg::ROW_W-1:0]                     i_job_row,
    input  logic [$clog2(MAX_WIDTH)-1:0]                  i_job_col,
    input  logic [$clog2(2*MAX_RADIUS+2)-1:0]             i_job_slot,
    input  logic                                          i_job_last,
    output logic                                          o_job_take,
    output logic                                          o_busy,
    output logic [$clog2((2*MAX_RADIUS+2)*MAX_WIDTH)-1:0] o_ram_raddr,
    input  logic [swc_pkg::BIN_W-1:0]                     i_ram_rdata,
    output logic                                          o_out_valid,
    input  logic                                          i_out_stall,
    output swc_pkg::t_out_item                            o_out_data
);
    import swc_pkg::*;

    localparam int SLOTS = 2 * MAX_RADIUS + 2;
    localparam int SLOTW = $clog2(SLOTS);
    localparam int COLW  = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int RW    = $clog2(MAX_RADIUS + 1);
    localparam int XSW   = ((COLW > RW) ? COLW : RW) + 1;
    localparam int YSW   = ((ROW_W > RW) ? ROW_W : RW) + 1;
    localparam int SIDEW = $clog2(2 * MAX_RADIUS + 2);
    localparam int AREAW = 2 * SIDEW;
    localparam int SUMW  = AREAW + 1;
    localparam int PRODW = CLIP_W + AREAW;
    localparam int T8W   = (PRODW - 8 > 9) ? PRODW - 8 : 9;
    localparam int CMPW  = (AREAW + 8 > T8W) ? AREAW + 8 : T8W;
    localparam int NUMW  = SUMW + 8;
    localparam int DCW   = $clog2(NUMW + 1);
    localparam int ADDRW = $clog2(SLOTS * MAX_WIDTH);

    t_back_state r_state, n_state;

    logic [ROW_W-1:0] r_y, r_wy, r_y1;
    logic [COLW-1:0]  r_x, r_wx, r_x0, r_x1;
    logic [SLOTW-1:0] r_slot, r_wslot;
    logic             r_last;
    logic [SIDEW-1:0] r_side, r_ah, r_aw;
    logic [AREAW-1:0] r_side2, r_area, r_rem;
    logic [T8W-1:0]   r_t8, r_lo, r_hi;
    logic [BIN_W-1:0] r_p, r_bin, r_i;
    logic [BINS-1:0]  r_hvalid;
    logic [SUMW-1:0]  r_excess, r_sum;
    logic [NUMW-1:0]  r_num;
    logic [DCW-1:0]   r_dcnt;
    logic             r_ov;
    t_out_item        r_od;

    logic [ROW_W-1:0] c_y0, c_y1, c_hm1, c_dy;
    logic [COLW-1:0]  c_x0, c_x1, c_wm1;
    logic [YSW-1:0]   c_ysum;
    logic [XSW-1:0]   c_xsum;
    logic [SLOTW:0]   c_sl;
    logic [SLOTW-1:0] c_slot0;
    logic [PRODW-1:0] c_prod;
    logic [AREAW-1:0] c_hrd, c_bincnt, c_icnt;
    logic             c_clip, c_lt_rem, c_qbit, c_out_load;
    logic [SUMW-1:0]  c_inc;
    logic [AREAW:0]   c_trial;
    logic [BIN_W-1:0] h_raddr, h_waddr;
    logic [AREAW-1:0] h_wdata;
    logic             h_we;

    swc_ram #(
        .WIDTH (AREAW),
        .DEPTH (BINS)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (h_we),
        .i_waddr (h_waddr),
        .i_wdata (h_wdata),
        .i_raddr (h_raddr),
        .o_rdata (c_hrd)
    );

    // window bounds clamped to the image
    always_comb begin
        c_hm1  = ROW_W'(i_eff_h - CFG_H_W'(1));
        c_wm1  = COLW'(i_eff_w - WW'(1));
        c_y0   = (YSW'(r_y) > YSW'(i_eff_r)) ? ROW_W'(YSW'(r_y) - YSW'(i_eff_r)) : '0;
        c_ysum = YSW'(r_y) + YSW'(i_eff_r);
        c_y1   = (c_ysum > YSW'(c_hm1)) ? c_hm1 : ROW_W'(c_ysum);
        c_x0   = (XSW'(r_x) > XSW'(i_eff_r)) ? COLW'(XSW'(r_x) - XSW'(i_eff_r)) : '0;
        c_xsum = XSW'(r_x) + XSW'(i_eff_r);
        c_x1   = (c_xsum > XSW'(c_wm1)) ? c_wm1 : COLW'(c_xsum);
        c_dy   = r_y - c_y0;
        c_sl   = (SLOTW+1)'(r_slot) - (SLOTW+1)'(c_dy);
        c_slot0 = c_sl[SLOTW] ? SLOTW'(c_sl + (SLOTW+1)'(SLOTS)) : c_sl[SLOTW-1:0];
    end

    assign c_prod   = PRODW'(i_clip) * PRODW'(r_side2);
    assign c_bincnt = r_hvalid[r_bin] ? c_hrd : '0;
    assign c_icnt   = r_hvalid[r_i] ? c_hrd : '0;
    assign c_clip   = ({CMPW'(c_icnt), 8'b0} >> 8 << 8) > CMPW'(r_t8) ?
                      1'b1 : (CMPW'({c_icnt, 8'b0}) > CMPW'(r_t8));
    assign c_inc    = r_excess >> 8;
    assign c_lt_rem = r_i < r_excess[7:0];
    assign c_trial  = {r_rem, r_num[NUMW-1]};
    assign c_qbit   = c_trial >= (AREAW+1)'(r_area);
    assign c_out_load = (r_state == BK_DONE) && (!r_ov || !i_out_stall);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE:  if (i_job_valid) n_state = BK_SETUP;
            BK_SETUP: n_state = BK_THR;
            BK_THR:   n_state = BK_THR2;
            BK_THR2:  n_state = BK_THR3;
            BK_THR3:  n_state = BK_WRD;
            BK_WRD:   n_state = BK_WBIN;
            BK_WBIN:  n_state = BK_WINC;
            BK_WINC: begin
                if (r_wx == r_x1 && r_wy == r_y1) n_state = BK_CLRD;
                else n_state = BK_WRD;
            end
            BK_CLRD:  n_state = BK_CLWR;
            BK_CLWR: begin
                if (r_i == 8'hFF) n_state = BK_SUMRD;
                else n_state = BK_CLRD;
            end
            BK_SUMRD: n_state = BK_SUMAC;
            BK_SUMAC: begin
                if (r_i == r_p) n_state = BK_MUL;
                else n_state = BK_SUMRD;
            end
            BK_MUL:   n_state = BK_DIV;
            BK_DIV:   if (r_dcnt == DCW'(1)) n_state = BK_DONE;
            BK_DONE:  if (c_out_load) n_state = BK_IDLE;
            default:  n_state = BK_IDLE;
        endcase
    end

    // memory controls
    always_comb begin
        o_ram_raddr = ADDRW'(r_wslot) * ADDRW'(MAX_WIDTH) + ADDRW'(r_wx);
        h_raddr     = r_i;
        h_we        = 1'b0;
        h_waddr     = r_i;
        h_wdata     = AREAW'(r_lo);
        unique case (r_state)
            BK_THR: o_ram_raddr = ADDRW'(r_slot) * ADDRW'(MAX_WIDTH) + ADDRW'(r_x);
            BK_WBIN: h_raddr = i_ram_rdata;
            BK_WINC: begin
                h_we    = 1'b1;
                h_waddr = r_bin;
                h_wdata = c_bincnt + AREAW'(1);
            end
            BK_CLWR: h_we = c_clip;
            default: ;
        endcase
    end

    assign o_job_take = (r_state == BK_IDLE) && i_job_valid;
    assign o_busy     = (r_state != BK_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (c_out_load) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            BK_IDLE: begin
                r_y    <= i_job_row;
                r_x    <= i_job_col;
                r_slot <= i_job_slot;
                r_last <= i_job_last;
            end
            BK_SETUP: begin
                r_wy     <= c_y0;
                r_y1     <= c_y1;
                r_x0     <= c_x0;
                r_wx     <= c_x0;
                r_x1     <= c_x1;
                r_wslot  <= c_slot0;
                r_ah     <= SIDEW'(c_y1 - c_y0 + ROW_W'(1));
                r_aw     <= SIDEW'(c_x1 - c_x0 + COLW'(1));
                r_side   <= SIDEW'({i_eff_r, 1'b1});
                r_hvalid <= '0;
            end
            BK_THR: begin
                r_side2 <= AREAW'(r_side) * AREAW'(r_side);
                r_area  <= AREAW'(r_ah) * AREAW'(r_aw);
            end
            BK_THR2: begin
                r_p <= i_ram_rdata;
                if (c_prod[PRODW-1:8] < (PRODW-8)'(256)) begin
                    r_t8 <= T8W'(256);
                end else begin
                    r_t8 <= T8W'(c_prod[PRODW-1:8]);
                end
            end
            BK_THR3: begin
                r_lo     <= r_t8 >> 8;
                r_hi     <= T8W'(({1'b0, r_t8} + (T8W+1)'(255)) >> 8);
                r_excess <= '0;
            end
            BK_WBIN: r_bin <= i_ram_rdata;
            BK_WINC: begin
                r_hvalid[r_bin] <= 1'b1;
                if (r_wx == r_x1) begin
                    r_wx    <= r_x0;
                    r_wy    <= r_wy + ROW_W'(1);
                    r_wslot <= (r_wslot == SLOTW'(SLOTS - 1)) ? '0 : r_wslot + SLOTW'(1);
                end else begin
                    r_wx <= r_wx + COLW'(1);
                end
                r_i <= '0;
            end
            BK_CLWR: begin
                if (c_clip) begin
                    r_excess <= r_excess + SUMW'(c_icnt - AREAW'(r_hi));
                end
                r_i   <= r_i + BIN_W'(1);
                r_sum <= '0;
            end
            BK_SUMAC: begin
                r_sum <= r_sum + SUMW'(c_icnt) + c_inc + SUMW'(c_lt_rem);
                r_i   <= r_i + BIN_W'(1);
            end
            BK_MUL: begin
                r_num  <= (NUMW'(r_sum) << 8) - NUMW'(r_sum);
                r_rem  <= '0;
                r_dcnt <= DCW'(NUMW);
            end
            BK_DIV: begin
                r_rem  <= c_qbit ? AREAW'(c_trial - (AREAW+1)'(r_area)) : AREAW'(c_trial);
                r_num  <= {r_num[NUMW-2:0], c_qbit};
                r_dcnt <= r_dcnt - DCW'(1);
            end
            default: ;
        endcase
        if (c_out_load) begin
            r_od.pixel_out <= (|r_num[NUMW-1:8]) ? 8'hFF : r_num[7:0];
            r_od.last      <= r_last;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_od;
endmodule

FILE: hw/rtl/sliding_window_clahe_top.sv
// ----------------------------------------------------------------------------
// sliding_window_clahe_top
// sliding window contrast limited histogram equalization of 8-bit images
// ----------------------------------------------------------------------------
// Pixels go in raster order as push items; a result leaves once its whole
// window has arrived, and drain items fetch the tail after the last pixel.
// Once the item that releases a result is accepted, the back end works it
// through its one-bin-per-step histogram ram: it adds each pixel of the
// clamped window (area A, up to 4225 at radius 32), clips all 256 bins,
// sums the bins up to the pixel value p, then divides one quotient bit per
// step over the width of the divider, NUMW (23). While a result is worked
// on, items stall.
module sliding_window_clahe_top #(
    parameter int MAX_WIDTH  = swc_pkg::MAX_WIDTH_DEF,
    parameter int MAX_RADIUS = swc_pkg::MAX_RADIUS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  swc_pkg::t_in_item             i_in_data,
    output logic                          o_in_stall,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output swc_pkg::t_out_item            o_out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [swc_pkg::PADDR_W-1:0]   paddr,
    input  logic [swc_pkg::PDATA_W-1:0]   pwdata,
    output logic [swc_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import swc_pkg::*;

    localparam int SLOTS = 2 * MAX_RADIUS + 2;
    localparam int SLOTW = $clog2(SLOTS);
    localparam int COLW  = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int RW    = $clog2(MAX_RADIUS + 1);
    localparam int ADDRW = $clog2(SLOTS * MAX_WIDTH);

    logic [CFG_W_W-1:0] r_width;
    logic [CFG_H_W-1:0] r_height;
    logic [CFG_R_W-1:0] r_radius;
    logic [CLIP_W-1:0]  r_clip;

    logic               c_cfg_wr;
    logic [WW-1:0]      c_eff_w;
    logic [CFG_H_W-1:0] c_eff_h;
    logic [RW-1:0]      c_eff_r;

    logic               job_valid, job_last, job_take, back_busy;
    logic [ROW_W-1:0]   job_row;
    logic [COLW-1:0]    job_col;
    logic [SLOTW-1:0]   job_slot;
    logic               ram_we;
    logic [ADDRW-1:0]   ram_waddr, ram_raddr;
    logic [BIN_W-1:0]   ram_wdata, ram_rdata;

    assign pready   = 1'b1;
    assign c_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
            r_radius <= RADIUS_RST;
            r_clip   <= CLIP_RST;
        end else if (c_cfg_wr) begin
            unique case (paddr[3:2])
                REG_WIDTH:  r_width  <= pwdata[CFG_W_W-1:0];
                REG_HEIGHT: r_height <= pwdata[CFG_H_W-1:0];
                REG_RADIUS: r_radius <= pwdata[CFG_R_W-1:0];
                REG_CLIP:   r_clip   <= pwdata[CLIP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[3:2])
            REG_WIDTH:  prdata = PDATA_W'(r_width);
            REG_HEIGHT: prdata = PDATA_W'(r_height);
            REG_RADIUS: prdata = PDATA_W'(r_radius);
            REG_CLIP:   prdata = PDATA_W'(r_clip);
            default: ;
        endcase
    end

    // out of range settings fold to the nearest supported value
    always_comb begin
        if (r_width == '0) c_eff_w = WW'(1);
        else if (r_width > CFG_W_W'(MAX_WIDTH)) c_eff_w = WW'(MAX_WIDTH);
        else c_eff_w = WW'(r_width);
        if (r_height == '0) c_eff_h = CFG_H_W'(1);
        else if (r_height > CFG_H_W'(HEIGHT_CAP)) c_eff_h = CFG_H_W'(HEIGHT_CAP);
        else c_eff_h = r_height;
        if (r_radius > CFG_R_W'(MAX_RADIUS)) c_eff_r = RW'(MAX_RADIUS);
        else c_eff_r = RW'(r_radius);
    end

    swc_ram #(
        .WIDTH (BIN_W),
        .DEPTH (SLOTS * MAX_WIDTH)
    ) u_rows (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    swc_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .i_cfg_wr    (c_cfg_wr),
        .i_eff_w     (c_eff_w),
        .i_eff_h     (c_eff_h),
        .i_eff_r     (c_eff_r),
        .i_back_busy (back_busy),
        .i_job_take  (job_take),
        .o_job_valid (job_valid),
        .o_job_row   (job_row),
        .o_job_col   (job_col),
        .o_job_slot  (job_slot),
        .o_job_last  (job_last),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata)
    );

    swc_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_eff_w     (c_eff_w),
        .i_eff_h     (c_eff_h),
        .i_eff_r     (c_eff_r),
        .i_clip      (r_clip),
        .i_job_valid (job_valid),
        .i_job_row   (job_row),
        .i_job_col   (job_col),
        .i_job_slot  (job_slot),
        .i_job_last  (job_last),
        .o_job_take  (job_take),
        .o_busy      (back_busy),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );
endmodule

FILE: hw/rtl/swc_checker.sv
// ----------------------------------------------------------------------------
// swc_checker
// port level checks of the sliding window clahe block
// ----------------------------------------------------------------------------
module swc_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input swc_pkg::t_in_item           i_in_data,
    input logic                        o_in_stall,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input swc_pkg::t_out_item          o_out_data,
    input logic                        psel,
    input logic                        penable,
    input logic                        pwrite,
    input logic [swc_pkg::PADDR_W-1:0] paddr,
    input logic [swc_pkg::PDATA_W-1:0] pwdata,
    input logic [swc_pkg::PDATA_W-1:0] prdata,
    input logic                        pready
);
    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // a new result only comes from work that held off the input
    a_rose_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without busy back end");

    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result right after reset");

    a_prdata_w: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready && prdata[31:12] == 20'd0)
        else $error("register read out of range");
endmodule

bind sliding_window_clahe_top swc_checker u_swc_checker (.*);
